// ----- rtl/sscc_pkg.sv -----
// ----------------------------------------------------------------------------
// sscc_pkg
// Shared widths, codes and types for the segment set crossing checker.
// ----------------------------------------------------------------------------
package sscc_pkg;

  localparam int COORD_W      = 16;
  localparam int MAX_SEGMENTS = 32;
  localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int OP_W         = 2;
  localparam int PT_TOL_W     = 8;
  localparam int CR_TOL_W     = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS_TOL = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic             no_crossing;
    logic [CNT_W-1:0] stored_count;
    logic             store_full_error;
  } out_item_t;

  typedef struct packed {
    logic              capture;
    logic              clear;
    logic              insert;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] count;
    logic             pipe_busy;
  } dp_status_t;

endpackage

// ----- rtl/segment_set_crossing_check.sv -----
// ----------------------------------------------------------------------------
// segment_set_crossing_check
// Store of 2D segments with clear, insert and crossing test against the store.
// ----------------------------------------------------------------------------
//  Channel | Ports                                     | Handshake
//  --------+-------------------------------------------+------------------------------
//  input   | start, busy, in_data                      | item taken on start && !busy
//  result  | out_valid, out_data                       | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write on valid && ready
//
//  A clear, insert or unused opcode keeps busy high through the execute and report
//  states; the result shows in the report state. A test keeps busy high while the
//  scan reads one stored segment per cycle from the store port into a four-stage
//  pipeline, which must drain before the result. Reset empties the store and zeroes
//  both tolerances. The result strobe lasts one cycle and cannot be held off.
module segment_set_crossing_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  sscc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output sscc_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sscc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sscc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sscc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sscc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sscc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/sscc_dpath.sv -----
// ----------------------------------------------------------------------------
// sscc_dpath
// Segment store, tolerance registers and the four-stage crossing pipeline.
// ----------------------------------------------------------------------------
module sscc_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sscc_pkg::in_item_t              in_data,
  input  logic                            cfg_wr,
  input  logic [sscc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sscc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  sscc_pkg::dp_cmd_t               cmd,
  output sscc_pkg::dp_status_t            status,
  output sscc_pkg::out_item_t             out_data
);
  import sscc_pkg::*;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int NCROSS  = 6;

  localparam logic [1:0] SGN_ZERO = 2'b00;
  localparam logic [1:0] SGN_POS  = 2'b01;
  localparam logic [1:0] SGN_NEG  = 2'b11;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } seg_t;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  function automatic diff_t sub(input logic signed [COORD_W-1:0] p,
                                input logic signed [COORD_W-1:0] q);
    return DIFF_W'(p) - DIFF_W'(q);
  endfunction

  function automatic logic in_tol(input diff_t d, input logic [PT_TOL_W-1:0] tol);
    diff_t t;
    t = $signed(DIFF_W'(tol));
    return (d <= t) && (d >= -t);
  endfunction

  function automatic logic ranges_meet(input logic signed [COORD_W-1:0] a,
                                       input logic signed [COORD_W-1:0] b,
                                       input logic signed [COORD_W-1:0] c,
                                       input logic signed [COORD_W-1:0] d,
                                       input logic [PT_TOL_W-1:0] tol);
    logic signed [COORD_W-1:0] lo_ab, hi_ab, lo_cd, hi_cd, lo, hi;
    lo_ab = (a > b) ? b : a;
    hi_ab = (a > b) ? a : b;
    lo_cd = (c > d) ? d : c;
    hi_cd = (c > d) ? c : d;
    lo    = (lo_ab > lo_cd) ? lo_ab : lo_cd;
    hi    = (hi_ab < hi_cd) ? hi_ab : hi_cd;
    return sub(lo, hi) <= $signed(DIFF_W'(tol));
  endfunction

  logic [PT_TOL_W-1:0] pt_tol_r;
  logic [CR_TOL_W-1:0] cr_tol_r;
  logic [OP_W-1:0]     op_r;
  seg_t                query_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                err_r;
  logic                hit_r;
  logic                full;

  seg_t                mem [MAX_SEGMENTS];
  seg_t                rd_seg_r;
  logic                v1_r, v2_r, v3_r, v4_r;

  diff_t               ux_r [NCROSS];
  diff_t               uy_r [NCROSS];
  diff_t               vx_r [NCROSS];
  diff_t               vy_r [NCROSS];
  logic                adj2_r, xm2_r, ym2_r;
  prod_t               pa_r [NCROSS];
  prod_t               pb_r [NCROSS];
  logic                adj3_r, xm3_r, ym3_r;
  logic [1:0]          sgn_r [NCROSS];
  logic                adj4_r, xm4_r, ym4_r;

  diff_t               ux [NCROSS];
  diff_t               uy [NCROSS];
  diff_t               vx [NCROSS];
  diff_t               vy [NCROSS];
  diff_t               acx, acy, bcx, bcy, dcx, dcy, bax, bay, cax, cay, dax, day, bdx, bdy;
  logic                adj;
  logic                crossing;

  assign full = (count_r >= CNT_W'(MAX_SEGMENTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_tol_r <= '0;
      cr_tol_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_POINT_TOL: pt_tol_r <= cfg_data[PT_TOL_W-1:0];
        CFG_CROSS_TOL: cr_tol_r <= cfg_data[CR_TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.insert && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_CLEAR;
      count_r <= '0;
      err_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.capture) begin
        op_r  <= in_data.opcode;
        err_r <= 1'b0;
      end else if (cmd.insert && full) begin
        err_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      query_r <= '{in_data.start_x, in_data.start_y, in_data.end_x, in_data.end_y};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      mem[count_r[ADDR_W-1:0]] <= query_r;
    end
    if (cmd.rd_en) begin
      rd_seg_r <= mem[cmd.rd_addr];
    end
  end

  // Stored segment is a-b, query segment is c-d.
  always_comb begin
    acx = sub(rd_seg_r.start_x, query_r.start_x);
    acy = sub(rd_seg_r.start_y, query_r.start_y);
    bcx = sub(rd_seg_r.end_x,   query_r.start_x);
    bcy = sub(rd_seg_r.end_y,   query_r.start_y);
    dcx = sub(query_r.end_x,    query_r.start_x);
    dcy = sub(query_r.end_y,    query_r.start_y);
    bax = sub(rd_seg_r.end_x,   rd_seg_r.start_x);
    bay = sub(rd_seg_r.end_y,   rd_seg_r.start_y);
    cax = sub(query_r.start_x,  rd_seg_r.start_x);
    cay = sub(query_r.start_y,  rd_seg_r.start_y);
    dax = sub(query_r.end_x,    rd_seg_r.start_x);
    day = sub(query_r.end_y,    rd_seg_r.start_y);
    bdx = sub(rd_seg_r.end_x,   query_r.end_x);
    bdy = sub(rd_seg_r.end_y,   query_r.end_y);

    ux[0] = acx; uy[0] = acy; vx[0] = dcx; vy[0] = dcy;
    ux[1] = bcx; uy[1] = bcy; vx[1] = dcx; vy[1] = dcy;
    ux[2] = bax; uy[2] = bay; vx[2] = cax; vy[2] = cay;
    ux[3] = bax; uy[3] = bay; vx[3] = dax; vy[3] = day;
    ux[4] = dcx; uy[4] = dcy; vx[4] = acx; vy[4] = acy;
    ux[5] = dcx; uy[5] = dcy; vx[5] = bcx; vy[5] = bcy;

    adj = (in_tol(acx, pt_tol_r) && in_tol(acy, pt_tol_r)) ||
          (in_tol(dax, pt_tol_r) && in_tol(day, pt_tol_r)) ||
          (in_tol(bcx, pt_tol_r) && in_tol(bcy, pt_tol_r)) ||
          (in_tol(bdx, pt_tol_r) && in_tol(bdy, pt_tol_r));
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NCROSS; k++) begin
      ux_r[k] <= ux[k];
      uy_r[k] <= uy[k];
      vx_r[k] <= vx[k];
      vy_r[k] <= vy[k];
      pa_r[k] <= PROD_W'(ux_r[k]) * PROD_W'(vy_r[k]);
      pb_r[k] <= PROD_W'(uy_r[k]) * PROD_W'(vx_r[k]);
    end
    adj2_r <= adj;
    xm2_r  <= ranges_meet(rd_seg_r.start_x, rd_seg_r.end_x,
                          query_r.start_x, query_r.end_x, pt_tol_r);
    ym2_r  <= ranges_meet(rd_seg_r.start_y, rd_seg_r.end_y,
                          query_r.start_y, query_r.end_y, pt_tol_r);
    adj3_r <= adj2_r;
    xm3_r  <= xm2_r;
    ym3_r  <= ym2_r;
    adj4_r <= adj3_r;
    xm4_r  <= xm3_r;
    ym4_r  <= ym3_r;
  end

  always_ff @(posedge clk) begin
    logic signed [CROSS_W-1:0] c;
    logic signed [CROSS_W-1:0] t;
    t = $signed(CROSS_W'(cr_tol_r));
    for (int k = 0; k < NCROSS; k++) begin
      c = CROSS_W'(pa_r[k]) - CROSS_W'(pb_r[k]);
      if ((c <= t) && (c >= -t)) begin
        sgn_r[k] <= SGN_ZERO;
      end else if (c < 0) begin
        sgn_r[k] <= SGN_NEG;
      end else begin
        sgn_r[k] <= SGN_POS;
      end
    end
  end

  always_comb begin
    if ((sgn_r[0] == SGN_ZERO) && (sgn_r[1] == SGN_ZERO)) begin
      crossing = !adj4_r && xm4_r && ym4_r;
    end else begin
      crossing = !adj4_r && (sgn_r[2] != sgn_r[3]) && (sgn_r[4] != sgn_r[5]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (cmd.capture) begin
        hit_r <= 1'b0;
      end else if (v4_r && crossing) begin
        hit_r <= 1'b1;
      end
    end
  end

  assign status.op        = op_r;
  assign status.count     = count_r;
  assign status.pipe_busy = v1_r | v2_r | v3_r | v4_r;

  assign out_data.no_crossing      = (op_r == OP_TEST) && !hit_r;
  assign out_data.stored_count     = count_r;
  assign out_data.store_full_error = err_r;

endmodule

// ----- rtl/sscc_ctrl.sv -----
// ----------------------------------------------------------------------------
// sscc_ctrl
// Sequencer: takes an item, runs the operation or the store scan, reports.
// ----------------------------------------------------------------------------
module sscc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  sscc_pkg::dp_status_t status,
  output sscc_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import sscc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.rd_addr = idx_r[ADDR_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        idx_nxt = '0;
        case (status.op)
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = ST_REPORT;
          end
          OP_INSERT: begin
            cmd.insert = 1'b1;
            state_nxt  = ST_REPORT;
          end
          OP_TEST: state_nxt = ST_SCAN;
          default: state_nxt = ST_REPORT;
        endcase
      end
      ST_SCAN: begin
        if (idx_r == status.count) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_REPORT);

endmodule

// ----- rtl/sscc_checker.sv -----
// ----------------------------------------------------------------------------
// sscc_checker
// Port-level checks on the segment set crossing checker, bound to the top.
// ----------------------------------------------------------------------------
module sscc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input sscc_pkg::out_item_t out_data
);
  import sscc_pkg::*;

  a_take_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.stored_count <= CNT_W'(MAX_SEGMENTS))
    else $error("stored count beyond store depth");

  a_full_error_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.store_full_error |->
      out_data.stored_count == CNT_W'(MAX_SEGMENTS) && !out_data.no_crossing)
    else $error("full error with store not full");

endmodule

bind segment_set_crossing_check sscc_checker u_sscc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
